// File: rtl/core/dual_mode_uart_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// Frame receiver assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_MODE_UART_FRAME_RECEIVER_DEFINES_SVH
`define DUAL_MODE_UART_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication
`define DMUFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// next-cycle implication
`define DMUFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

// File: rtl/core/dmufr_pkg.sv
// ----------------------------------------------------------------------------
// Frame receiver package
// Payload types, state codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package dmufr_pkg;

  localparam int BYTE_W     = 8;
  localparam int FLEN_W     = 6;
  localparam int FIXLEN_W   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_END  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_MODE  = 3'd5;

  localparam logic [FIXLEN_W-1:0] FIXED_LEN_RST = 6'd8;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ECHO  = 1'b1;
  localparam logic TYPE_FIXED = 1'b0;
  localparam logic TYPE_DELIM = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              frame_type;
    logic [FLEN_W-1:0] frame_len;
    logic              last;
  } frm_item_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_FIXED = 3'b010,
    MODE_DELIM = 3'b100
  } mode_e;

  typedef enum logic [1:0] {
    ST_RX   = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/dmufr_stream_if.sv
// ----------------------------------------------------------------------------
// Frame receiver stream channel
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmufr_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dual_mode_uart_frame_receiver.sv
// ----------------------------------------------------------------------------
// Dual-mode serial frame receiver
// A byte request is taken while receiving with the output register free;
// an echo result is valid the cycle after. A completed frame streams out
// of the assembly RAM read port one byte per cycle unless the output stalls,
// once the closing request enters the emit state; input is held off meanwhile.
// Reset clears config, fill count and mode; the RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_mode_uart_frame_receiver_defines.svh"

module dual_mode_uart_frame_receiver #(
  parameter int FRAME_MAX = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [dmufr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dmufr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  dmufr_stream_if.sink                            rx_i,
  dmufr_stream_if.source                          frm_o
);
  import dmufr_pkg::*;

  localparam int CW = $clog2(FRAME_MAX + 1);
  localparam int AW = $clog2(FRAME_MAX);
  localparam int LW = (CW > FIXLEN_W) ? CW : FIXLEN_W;
  localparam logic [CW-1:0] FILL_MAX = CW'(FRAME_MAX);

  // configuration
  logic [BYTE_W-1:0]   hdr_first_q, hdr_second_q, delim_start_q, delim_end_q;
  logic [FIXLEN_W-1:0] fixed_len_q;
  logic                echo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q   <= '0;
      hdr_second_q  <= '0;
      delim_start_q <= '0;
      delim_end_q   <= '0;
      fixed_len_q   <= FIXED_LEN_RST;
      echo_q        <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HDR_FIRST:   hdr_first_q   <= cfg_data_i;
        CFG_HDR_SECOND:  hdr_second_q  <= cfg_data_i;
        CFG_DELIM_START: delim_start_q <= cfg_data_i;
        CFG_DELIM_END:   delim_end_q   <= cfg_data_i;
        CFG_FIXED_LEN:   fixed_len_q   <= cfg_data_i[FIXLEN_W-1:0];
        CFG_ECHO_MODE:   echo_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // control state
  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [CW-1:0]     rd_cnt_q, rd_cnt_d;
  logic              type_q, type_d;
  logic [FLEN_W-1:0] len_q, len_d;

  // output register
  logic              out_valid_q;
  logic              kind_q, ftype_q, last_q;
  logic [BYTE_W-1:0] rd_data_q;
  logic [FLEN_W-1:0] flen_q;

  logic              out_free, rx_ready, rx_fire;
  logic [BYTE_W-1:0] rx_byte;
  logic              wr_en, rd_en, echo_go;
  logic [AW-1:0]     wr_addr;
  logic              rd_last;

  logic [BYTE_W-1:0] frame_mem [FRAME_MAX];

  assign rx_byte  = rx_i.payload.rx_byte;
  assign out_free = !out_valid_q || frm_o.ready;
  // interlock: no byte request while a frame streams out of the RAM
  assign rx_ready = (state_q == ST_RX) && out_free;
  assign rx_fire  = rx_i.valid && rx_ready;
  assign rd_last  = (rd_cnt_q + CW'(1)) == fill_q;

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    fill_d   = fill_q;
    rd_cnt_d = rd_cnt_q;
    type_d   = type_q;
    len_d    = len_q;
    wr_en    = 1'b0;
    wr_addr  = fill_q[AW-1:0];
    rd_en    = 1'b0;
    echo_go  = 1'b0;

    if (state_q == ST_RX) begin
      if (rx_fire) begin
        if (echo_q) begin
          echo_go = 1'b1;
        end else begin
          case (mode_q)
            MODE_DELIM: begin
              if (rx_byte == hdr_first_q) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                fill_d  = CW'(1);
                mode_d  = MODE_FIXED;
              end else if (rx_byte == delim_start_q) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                fill_d  = CW'(1);
                mode_d  = MODE_DELIM;
              end else begin
                if (fill_q < FILL_MAX) begin
                  wr_en  = 1'b1;
                  fill_d = fill_q + CW'(1);
                end
                if (rx_byte == delim_end_q) begin
                  state_d  = ST_EMIT;
                  rd_cnt_d = '0;
                  type_d   = TYPE_DELIM;
                  len_d    = FLEN_W'(fill_d);
                end else if (fill_d >= FILL_MAX) begin
                  fill_d = '0;
                  mode_d = MODE_IDLE;
                end
              end
            end
            default: begin
              if (fill_q == '0) begin
                if (rx_byte == hdr_first_q) begin
                  wr_en  = 1'b1;
                  fill_d = CW'(1);
                  mode_d = MODE_FIXED;
                end else if (rx_byte == delim_start_q) begin
                  wr_en  = 1'b1;
                  fill_d = CW'(1);
                  mode_d = MODE_DELIM;
                end
              end else if (fill_q == CW'(1) && rx_byte == hdr_second_q) begin
                wr_en  = 1'b1;
                fill_d = CW'(2);
              end else if (fill_q >= CW'(2)) begin
                if (fill_q < FILL_MAX) begin
                  wr_en  = 1'b1;
                  fill_d = fill_q + CW'(1);
                end
                if (LW'(fill_d) >= LW'(fixed_len_q) || fill_d >= FILL_MAX) begin
                  state_d  = ST_EMIT;
                  rd_cnt_d = '0;
                  type_d   = TYPE_FIXED;
                  len_d    = FLEN_W'(fill_d);
                end
              end else begin
                fill_d = '0;
                mode_d = MODE_IDLE;
              end
            end
          endcase
        end
      end
    end else begin
      if (rd_cnt_q < fill_q && out_free) begin
        rd_en    = 1'b1;
        rd_cnt_d = rd_cnt_q + CW'(1);
        if (rd_last) begin
          state_d = ST_RX;
          fill_d  = '0;
          mode_d  = MODE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RX;
      mode_q      <= MODE_IDLE;
      fill_q      <= '0;
      rd_cnt_q    <= '0;
      type_q      <= TYPE_FIXED;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      fill_q   <= fill_d;
      rd_cnt_q <= rd_cnt_d;
      type_q   <= type_d;
      len_q    <= len_d;
      if (rd_en || echo_go) begin
        out_valid_q <= 1'b1;
      end else if (frm_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // assembly RAM write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= rx_byte;
    end
  end

  // RAM read port doubles as the output payload register
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= frame_mem[rd_cnt_q[AW-1:0]];
      kind_q    <= KIND_FRAME;
      ftype_q   <= type_q;
      flen_q    <= len_q;
      last_q    <= rd_last;
    end else if (echo_go) begin
      rd_data_q <= rx_byte;
      kind_q    <= KIND_ECHO;
      ftype_q   <= TYPE_FIXED;
      flen_q    <= '0;
      last_q    <= 1'b1;
    end
  end

  assign rx_i.ready               = rx_ready;
  assign frm_o.valid              = out_valid_q;
  assign frm_o.payload.kind       = kind_q;
  assign frm_o.payload.data       = rd_data_q;
  assign frm_o.payload.frame_type = ftype_q;
  assign frm_o.payload.frame_len  = flen_q;
  assign frm_o.payload.last       = last_q;

  `DMUFR_ASSERT_NOW(a_no_rx_in_emit, state_q == ST_EMIT, !rx_i.ready)
  `DMUFR_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FILL_MAX)
  `DMUFR_ASSERT_NOW(a_emit_pending, state_q == ST_EMIT, rd_cnt_q < fill_q)
  `DMUFR_ASSERT_NEXT(a_last_read_idle, rd_en && rd_last,
                     state_q == ST_RX && fill_q == '0 && out_valid_q)

endmodule

`default_nettype wire
